// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the planar pixel decoder RTL.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Plain property, checked at every rising clock edge outside reset.
`define PVD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pvd assertion failed");
// Same-cycle implication.
`define PVD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pvd assertion failed");
// Next-cycle implication.
`define PVD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pvd assertion failed");
`else
`define PVD_ASSERT(lbl, clk, rst, prop)
`define PVD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PVD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/pvd_pkg.sv -----
// Package for the planar pixel decoder: payload and config types,
// register indexes and display mode codes. No dependencies.
package pvd_pkg;

  localparam int PIXELS_PER_WORD = 16;
  localparam int PIX_IDX_W       = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_DISPLAY_MODE  = 3'd0;
  localparam logic [2:0] REG_PALETTE_0     = 3'd1;
  localparam logic [2:0] REG_PALETTE_1     = 3'd2;
  localparam logic [2:0] REG_PALETTE_2     = 3'd3;
  localparam logic [2:0] REG_PALETTE_3     = 3'd4;
  localparam logic [2:0] REG_PALETTE_GROUP = 3'd5;

  // Display modes
  localparam logic [2:0] MODE_320_4C_P12  = 3'd0;
  localparam logic [2:0] MODE_320_4C_P34  = 3'd1;
  localparam logic [2:0] MODE_320_16C     = 3'd2;
  localparam logic [2:0] MODE_320_16C_ALT = 3'd3;
  localparam logic [2:0] MODE_640_2C_P12  = 3'd4;
  localparam logic [2:0] MODE_640_2C_P34  = 3'd5;
  localparam logic [2:0] MODE_640_4C      = 3'd6;
  localparam logic [2:0] MODE_640_4C_ALT  = 3'd7;

  typedef struct packed {
    logic [7:0] plane_one;
    logic [7:0] plane_two;
    logic [7:0] plane_three;
    logic [7:0] plane_four;
  } planes_t;

  typedef struct packed {
    logic [3:0] pixel_colour;
    logic       word_end;
  } pixel_t;

  typedef struct packed {
    logic [2:0]      display_mode;
    logic [3:0][3:0] palette;
    logic [1:0]      palette_group;
  } cfg_t;

endpackage

// ----- rtl/pvd_cfg_regs.sv -----
// Configuration register file of the planar pixel decoder.
// Depends on pvd_pkg.
module pvd_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [3:0]    cfg_data,
  output pvd_pkg::cfg_t cfg
);

  pvd_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg          = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pvd_pkg::REG_DISPLAY_MODE:  regs.display_mode  <= cfg_data[2:0];
        pvd_pkg::REG_PALETTE_0:     regs.palette[0]    <= cfg_data;
        pvd_pkg::REG_PALETTE_1:     regs.palette[1]    <= cfg_data;
        pvd_pkg::REG_PALETTE_2:     regs.palette[2]    <= cfg_data;
        pvd_pkg::REG_PALETTE_3:     regs.palette[3]    <= cfg_data;
        pvd_pkg::REG_PALETTE_GROUP: regs.palette_group <= cfg_data[1:0];
        default: ;  // index beyond the list: ignored
      endcase
    end
  end

endmodule

// ----- rtl/pvd_pixel_map.sv -----
// Combinational colour lookup for one pixel of a planar word.
// Depends on pvd_pkg.
module pvd_pixel_map (
  input  pvd_pkg::planes_t                planes,
  input  logic [pvd_pkg::PIX_IDX_W-1:0]   idx,
  input  pvd_pkg::cfg_t                   cfg,
  output logic [3:0]                      colour
);

  logic [2:0] lb;
  logic [2:0] hb;
  logic       odd;
  logic       a1, a2, a3, a4;   // bits at logical pixel (320 modes)
  logic       h1, h2, h3, h4;   // bits within half (640 modes)
  logic [3:0] code16;
  logic [1:0] code4;
  logic       use16;

  assign lb  = idx[3:1];
  assign hb  = idx[2:0];
  assign odd = idx[3];

  assign a1 = planes.plane_one[lb];
  assign a2 = planes.plane_two[lb];
  assign a3 = planes.plane_three[lb];
  assign a4 = planes.plane_four[lb];
  assign h1 = planes.plane_one[hb];
  assign h2 = planes.plane_two[hb];
  assign h3 = planes.plane_three[hb];
  assign h4 = planes.plane_four[hb];

  always_comb begin
    code16 = {a4, a3, a2, a1};
    code4  = 2'b00;
    use16  = 1'b0;
    unique case (cfg.display_mode)
      pvd_pkg::MODE_320_4C_P12: code4 = {a2, a1};
      pvd_pkg::MODE_320_4C_P34: code4 = {a4, a3};
      pvd_pkg::MODE_320_16C:    use16 = 1'b1;
      pvd_pkg::MODE_320_16C_ALT: begin
        use16 = 1'b1;
        // undocumented: group match repeats the upper bits
        if ({a4, a3} == cfg.palette_group) code16 = {a4, a3, a4, a3};
      end
      pvd_pkg::MODE_640_2C_P12: code4 = {1'b0, odd ? h2 : h1};
      pvd_pkg::MODE_640_2C_P34: code4 = {1'b0, odd ? h4 : h3};
      pvd_pkg::MODE_640_4C:     code4 = odd ? {h4, h2} : {h3, h1};
      pvd_pkg::MODE_640_4C_ALT: code4 = odd ? {h4, h4} : {h3, h3};
      default: ;
    endcase

    if (use16) begin
      if (code16[3:2] == cfg.palette_group) colour = cfg.palette[code16[1:0]];
      else                                  colour = code16;
    end else begin
      colour = cfg.palette[code4];
    end
  end

endmodule

// ----- rtl/planar_vram_pixel_decoder_top.sv -----
// Top level of the planar video word to pixel decoder.
// Depends on pvd_pkg, pvd_cfg_regs, pvd_pixel_map and assert_macros.svh.
//
// Usage:
//  - Input: a word of four plane bytes (planes) is taken at a rising edge
//    with start high and busy low. One transaction per word.
//  - Output: sixteen pixels per word, one per cycle, each shown on pixel
//    for exactly one cycle with strobe high; word_end marks the sixteenth.
//    The receiver has no back-pressure and must take every strobe.
//  - Config: cfg_valid/cfg_ready write channel, cfg_index selects the
//    register (mode, palette 0..3, palette group). cfg_ready is always high.
//    Write only while no word is in flight.
//  - First pixel: with the word slot free, an accepted word is loaded into the
//    current word register and its first pixel then into the result register.
//  - Throughput: one pixel per cycle, set by the result
//    register. A one-word holding register lets the next word be taken
//    while the current one is still streaming, so back-to-back words come
//    out with no gap; busy is high only while that holding register is full.
//  - Reset (synchronous, rst high): clears the config registers, both word
//    valid flags, the pixel counter and strobe.
`include "assert_macros.svh"

module planar_vram_pixel_decoder_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pvd_pkg::planes_t planes,
  output logic             strobe,
  output pvd_pkg::pixel_t  pixel,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [3:0]       cfg_data
);

  localparam logic [pvd_pkg::PIX_IDX_W-1:0] LAST_IDX =
    pvd_pkg::PIX_IDX_W'(pvd_pkg::PIXELS_PER_WORD - 1);

  pvd_pkg::cfg_t    cfg;
  pvd_pkg::planes_t cur;        // word being streamed out
  logic             cur_valid;
  pvd_pkg::planes_t held;       // next word, waiting
  logic             held_valid;
  logic [pvd_pkg::PIX_IDX_W-1:0] cnt;
  logic [3:0]       colour;
  logic             accept;
  logic             advance;

  pvd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pvd_pixel_map u_map (
    .planes (cur),
    .idx    (cnt),
    .cfg    (cfg),
    .colour (colour)
  );

  assign busy    = held_valid;
  assign accept  = start && !busy;
  // Current word slot frees up on its last pixel or when empty.
  assign advance = !cur_valid || (cnt == LAST_IDX);

  // Word slots and pixel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      held_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      if (advance) begin
        cnt <= '0;
        if (held_valid) begin
          cur        <= held;
          cur_valid  <= 1'b1;
          held_valid <= 1'b0;
        end else if (accept) begin
          cur       <= planes;
          cur_valid <= 1'b1;
        end else begin
          cur_valid <= 1'b0;
        end
      end else begin
        // slot is streaming and not on its last pixel
        cnt <= cnt + 1'b1;
        if (accept) begin
          held       <= planes;
          held_valid <= 1'b1;
        end
      end
    end
  end

  // Result register: one pixel per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cur_valid;
    end
    pixel.pixel_colour <= colour;
    pixel.word_end     <= (cnt == LAST_IDX);
  end

  // A word is only held while another is streaming.
  `PVD_ASSERT_IMP(a_held_needs_cur, clk, rst, held_valid, cur_valid)
  // Counter runs only with a word in the slot.
  `PVD_ASSERT_IMP(a_cnt_idle_zero, clk, rst, !cur_valid, cnt == '0)
  // A word taken into an empty slot starts at pixel zero.
  `PVD_ASSERT_NXT(a_fresh_start, clk, rst, accept && !cur_valid,
                  cur_valid && cnt == '0)
  // The last pixel's strobe implies a strobe at the first pixel of its word.
  `PVD_ASSERT_IMP(a_last_run, clk, rst, strobe && pixel.word_end,
                  $past(strobe, 15))

endmodule
